/* design/tfn_pkg.sv */
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and constants for the triangle face normal core
// Holds the request and result payload structs and the arithmetic widths
// used by the pipeline stages.
// ----------------------------------------------------------------------------
package tfn_pkg;

  // Field widths of the request and result payloads.
  localparam int CoordBits = 16;
  localparam int NormalBits = 16;
  localparam int FracBits = 14;

  // Internal widths: edge difference, product, cross magnitude, root, radicand.
  localparam int DiffBits = CoordBits + 1;
  localparam int ProdBits = 2 * DiffBits;
  localparam int MagBits = 2 * DiffBits;
  localparam int RootBits = MagBits + 1;
  localparam int RadBits = 2 * RootBits;

  typedef struct packed {
    logic signed [CoordBits-1:0] first_x;
    logic signed [CoordBits-1:0] first_y;
    logic signed [CoordBits-1:0] first_z;
    logic signed [CoordBits-1:0] second_x;
    logic signed [CoordBits-1:0] second_y;
    logic signed [CoordBits-1:0] second_z;
    logic signed [CoordBits-1:0] third_x;
    logic signed [CoordBits-1:0] third_y;
    logic signed [CoordBits-1:0] third_z;
  } tfn_req_t;

  typedef struct packed {
    logic signed [NormalBits-1:0] normal_x;
    logic signed [NormalBits-1:0] normal_y;
    logic signed [NormalBits-1:0] normal_z;
    logic                         degenerate;
  } tfn_res_t;

endpackage

/* design/tfn_divider.sv */
// ----------------------------------------------------------------------------
// tfn_divider: pipelined fractional divider
// Computes floor((mag << FRAC_BITS) / len) for mag <= len, one quotient bit
// per register stage, FRAC_BITS + 1 stages in all.
// ----------------------------------------------------------------------------
module tfn_divider #(
  parameter int LEN_BITS = 35,
  parameter int FRAC_BITS = 14
) (
  input  logic                clk,
  input  logic                adv,
  input  logic [LEN_BITS-1:0] mag,
  input  logic [LEN_BITS-1:0] len,
  output logic [FRAC_BITS:0]  quot
);

  logic [LEN_BITS-1:0]  rem  [FRAC_BITS+1];
  logic [LEN_BITS-1:0]  dvs  [FRAC_BITS+1];
  logic [FRAC_BITS:0]   q    [FRAC_BITS+1];

  // First stage: the integer bit, which is set only when mag equals len.
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= (mag >= len) ? mag - len : mag;
      dvs[0] <= len;
      q[0]   <= {{FRAC_BITS{1'b0}}, mag >= len};
    end
  end

  // Fraction stages: shift the remainder, compare and subtract once.
  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_step
    logic [LEN_BITS:0] r2;
    logic              ge;
    always_comb begin
      r2 = {rem[j], 1'b0};
      ge = r2 >= {1'b0, dvs[j]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[j+1] <= ge ? LEN_BITS'(r2 - {1'b0, dvs[j]}) : r2[LEN_BITS-1:0];
        dvs[j+1] <= dvs[j];
        q[j+1]   <= {q[j][FRAC_BITS-1:0], ge};
      end
    end
  end

  assign quot = q[FRAC_BITS];

endmodule

/* design/triangle_face_normal_core.sv */
// ----------------------------------------------------------------------------
// triangle_face_normal_core: unit face normal of a triangle
// Forms the edge cross product, its floor square root length and the
// normalized Q1.14 components in one fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage: a request carries the three corners of a triangle in signed Q8.8 on
// in_data, handshaken by in_valid and in_ready. Each request gives exactly one
// result on out_data (normal_x/y/z in signed Q1.14 and a degenerate flag),
// handshaken by out_valid and out_ready. Results leave in request order.
// The path from acceptance to out_valid runs through five arithmetic stages
// (edges, products, cross terms, squares, sum), 35 square root stages of one
// root bit each, 15 divider stages of one quotient bit each, and the output
// register. Throughput is one request per cycle unless the pipeline holds;
// the square root and divider pipelines set the depth, not the rate.
// When out_ready is low while a result is held, the whole pipeline holds and
// in_ready drops; no request is lost or repeated. Reset clears all valid bits,
// so the pipeline comes up empty; data registers are not reset.
// A triangle whose cross product is zero returns a zero vector with the
// degenerate flag set.
// ----------------------------------------------------------------------------
module triangle_face_normal_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tfn_pkg::tfn_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tfn_pkg::tfn_res_t out_data
);

  import tfn_pkg::*;

  localparam int DivStages = FracBits + 1;
  localparam logic [FracBits:0] Limit = {1'b1, {FracBits{1'b0}}};

  logic adv;

  // The pipeline moves as a whole whenever the output register can take data.
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: edge vectors from the first corner.
  logic                       v1;
  logic signed [DiffBits-1:0] ux, uy, uz, vx, vy, vz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ux <= DiffBits'(in_data.second_x) - DiffBits'(in_data.first_x);
      uy <= DiffBits'(in_data.second_y) - DiffBits'(in_data.first_y);
      uz <= DiffBits'(in_data.second_z) - DiffBits'(in_data.first_z);
      vx <= DiffBits'(in_data.third_x) - DiffBits'(in_data.first_x);
      vy <= DiffBits'(in_data.third_y) - DiffBits'(in_data.first_y);
      vz <= DiffBits'(in_data.third_z) - DiffBits'(in_data.first_z);
    end
  end

  // Stage 2: the six partial products of the cross product.
  logic                       v2;
  logic signed [ProdBits-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_yz <= ProdBits'(uy * vz);
      p_zy <= ProdBits'(uz * vy);
      p_zx <= ProdBits'(uz * vx);
      p_xz <= ProdBits'(ux * vz);
      p_xy <= ProdBits'(ux * vy);
      p_yx <= ProdBits'(uy * vx);
    end
  end

  // Stage 3: cross terms as sign and magnitude.
  logic                       v3;
  logic                       neg3 [3];
  logic [MagBits-1:0]         mag3 [3];
  logic signed [ProdBits:0]   term [3];

  always_comb begin
    term[0] = (ProdBits+1)'(p_yz) - (ProdBits+1)'(p_zy);
    term[1] = (ProdBits+1)'(p_zx) - (ProdBits+1)'(p_xz);
    term[2] = (ProdBits+1)'(p_xy) - (ProdBits+1)'(p_yx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_term
    always_ff @(posedge clk) begin
      if (adv) begin
        neg3[i] <= term[i][ProdBits];
        mag3[i] <= term[i][ProdBits] ? MagBits'(-term[i]) : MagBits'(term[i]);
      end
    end
  end

  // Stage 4: squares of the magnitudes and the zero-vector flag.
  logic                 v4, degen4;
  logic                 neg4 [3];
  logic [MagBits-1:0]   mag4 [3];
  logic [2*MagBits-1:0] sq4  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      degen4 <= (mag3[0] == '0) && (mag3[1] == '0) && (mag3[2] == '0);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sq
    always_ff @(posedge clk) begin
      if (adv) begin
        neg4[i] <= neg3[i];
        mag4[i] <= mag3[i];
        sq4[i]  <= mag3[i] * mag3[i];
      end
    end
  end

  // Square root pipeline: index 0 holds the squared length, each later index
  // one more root bit.
  logic               sv    [RootBits+1];
  logic               sdeg  [RootBits+1];
  logic               sneg  [RootBits+1][3];
  logic [MagBits-1:0] smag  [RootBits+1][3];
  logic [RadBits-1:0] rad   [RootBits+1];
  logic [RootBits+1:0] rem  [RootBits+1];
  logic [RootBits-1:0] root [RootBits+1];

  // Stage 5: sum of squares and an empty root.
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sdeg[0] <= degen4;
      rad[0]  <= RadBits'(sq4[0]) + RadBits'(sq4[1]) + RadBits'(sq4[2]);
      rem[0]  <= '0;
      root[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        sneg[0][i] <= neg4[i];
        smag[0][i] <= mag4[i];
      end
    end
  end

  // Each stage brings down two radicand bits and decides one root bit.
  for (genvar k = 0; k < RootBits; k++) begin : g_sqrt
    logic [RootBits+1:0] rsh;
    logic [RootBits+1:0] trial;
    logic                ge;
    always_comb begin
      rsh   = {rem[k][RootBits-1:0], rad[k][RadBits-1 -: 2]};
      trial = {root[k], 2'b01};
      ge    = rsh >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1]  <= ge ? rsh - trial : rsh;
        root[k+1] <= {root[k][RootBits-2:0], ge};
        rad[k+1]  <= {rad[k][RadBits-3:0], 2'b00};
        sdeg[k+1] <= sdeg[k];
        for (int i = 0; i < 3; i++) begin
          sneg[k+1][i] <= sneg[k][i];
          smag[k+1][i] <= smag[k][i];
        end
      end
    end
  end

  // Divider pipelines, one per component.
  logic [FracBits:0] quot [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    tfn_divider #(
      .LEN_BITS  (RootBits),
      .FRAC_BITS (FracBits)
    ) u_div (
      .clk  (clk),
      .adv  (adv),
      .mag  (RootBits'(smag[RootBits][i])),
      .len  (root[RootBits]),
      .quot (quot[i])
    );
  end

  // Sideband that travels beside the divider stages.
  logic dv   [DivStages];
  logic ddeg [DivStages];
  logic dneg [DivStages][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DivStages; j++) begin
        dv[j] <= 1'b0;
      end
    end else if (adv) begin
      dv[0] <= sv[RootBits];
      for (int j = 1; j < DivStages; j++) begin
        dv[j] <= dv[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ddeg[0] <= sdeg[RootBits];
      for (int i = 0; i < 3; i++) begin
        dneg[0][i] <= sneg[RootBits][i];
      end
      for (int j = 1; j < DivStages; j++) begin
        ddeg[j] <= ddeg[j-1];
        for (int i = 0; i < 3; i++) begin
          dneg[j][i] <= dneg[j-1][i];
        end
      end
    end
  end

  // Output register: clamp, apply sign, and zero the degenerate case.
  logic [NormalBits-1:0] comp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [NormalBits-1:0] qs;
      qs = NormalBits'((quot[i] > Limit) ? Limit : quot[i]);
      if (ddeg[DivStages-1]) begin
        comp[i] = '0;
      end else if (dneg[DivStages-1][i]) begin
        comp[i] = -qs;
      end else begin
        comp[i] = qs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[DivStages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.normal_x   <= comp[0];
      out_data.normal_y   <= comp[1];
      out_data.normal_z   <= comp[2];
      out_data.degenerate <= ddeg[DivStages-1];
    end
  end

endmodule
